### hw/rtl/bsc_pkg.sv
// Shared types, codes and helper functions for the banner service classifier.
package bsc_pkg;

    // Kept-character limit and the width of the counter that saturates at it
    localparam int KEPT_LIMIT = 256;
    localparam int KEPT_W     = $clog2(KEPT_LIMIT + 1);

    // Character window depth (cells in the chain)
    localparam int WIN_DEPTH  = 4;

    // Service codes
    localparam logic [3:0] SVC_UNKNOWN = 4'd0;
    localparam logic [3:0] SVC_SSH     = 4'd1;
    localparam logic [3:0] SVC_HTTP    = 4'd2;
    localparam logic [3:0] SVC_SMTP    = 4'd3;
    localparam logic [3:0] SVC_FTP     = 4'd4;
    localparam logic [3:0] SVC_TELNET  = 4'd5;
    localparam logic [3:0] SVC_DNS     = 4'd6;
    localparam logic [3:0] SVC_POP3    = 4'd7;
    localparam logic [3:0] SVC_IMAP    = 4'd8;
    localparam logic [3:0] SVC_HTTPS   = 4'd9;
    localparam logic [3:0] SVC_SMB     = 4'd10;
    localparam logic [3:0] SVC_RTSP    = 4'd11;
    localparam logic [3:0] SVC_RDP     = 4'd12;

    // Cleartext attention codes
    localparam logic [1:0] ATT_NONE  = 2'd0;
    localparam logic [1:0] ATT_ADMIN = 2'd1;
    localparam logic [1:0] ATT_FILE  = 2'd2;
    localparam logic [1:0] ATT_WEB   = 2'd3;

    // Hit flag positions
    localparam int HIT_SSH  = 0;
    localparam int HIT_HTTP = 1;
    localparam int HIT_SMTP = 2;
    localparam int HIT_FTP  = 3;

    // Characters of interest
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5a;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    // Input transfer payload
    typedef struct packed {
        logic        first_item;
        logic [15:0] port_number;
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        last_item;
    } in_item_t;

    // Result transfer payload
    typedef struct packed {
        logic [3:0] service_code;
        logic [1:0] attention_code;
    } out_item_t;

    // Per-cycle control for every window cell
    typedef struct packed {
        logic clear;   // new banner: drop held character
        logic shift;   // kept character: take neighbor's character
    } cell_ctrl_t;

    // Cleaned character
    typedef struct packed {
        logic       keep;
        logic [7:0] ch;
    } clean_t;

    // CR, LF and tab to space, drop other non-printables, fold upper case
    function automatic clean_t clean_byte(input logic [7:0] raw);
        clean_t r;
        r.keep = 1'b1;
        r.ch   = raw;
        if (raw == CH_CR || raw == CH_LF || raw == CH_TAB) begin
            r.ch = CH_SPACE;
        end
        else if (raw < CH_SPACE || raw > CH_TILDE) begin
            r.keep = 1'b0;
        end
        else if (raw >= CH_UC_A && raw <= CH_UC_Z) begin
            r.ch = raw + CH_CASE;
        end
        return r;
    endfunction

    // Well-known port table
    function automatic logic [3:0] port_service(input logic [15:0] port);
        logic [3:0] s;
        unique case (port)
            16'd21:                     s = SVC_FTP;
            16'd22:                     s = SVC_SSH;
            16'd23:                     s = SVC_TELNET;
            16'd25:                     s = SVC_SMTP;
            16'd53:                     s = SVC_DNS;
            16'd80, 16'd8000, 16'd8080: s = SVC_HTTP;
            16'd110:                    s = SVC_POP3;
            16'd143:                    s = SVC_IMAP;
            16'd443, 16'd8443:          s = SVC_HTTPS;
            16'd445:                    s = SVC_SMB;
            16'd554:                    s = SVC_RTSP;
            16'd3389:                   s = SVC_RDP;
            default:                    s = SVC_UNKNOWN;
        endcase
        return s;
    endfunction

    // Priority pick over hits, port table as fallback, then attention code
    function automatic out_item_t classify(input logic [3:0] hits, input logic [15:0] port);
        out_item_t r;
        if (hits[HIT_SSH]) begin
            r.service_code = SVC_SSH;
        end
        else if (hits[HIT_HTTP]) begin
            r.service_code = SVC_HTTP;
        end
        else if (hits[HIT_SMTP]) begin
            r.service_code = SVC_SMTP;
        end
        else if (hits[HIT_FTP]) begin
            r.service_code = SVC_FTP;
        end
        else begin
            r.service_code = port_service(port);
        end
        unique case (r.service_code)
            SVC_TELNET: r.attention_code = ATT_ADMIN;
            SVC_FTP:    r.attention_code = ATT_FILE;
            SVC_HTTP:   r.attention_code = ATT_WEB;
            default:    r.attention_code = ATT_NONE;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/bsc_cell.sv
// One character slot of the banner window; hands its character to the next slot.
module bsc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  bsc_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          char_in,
    input  logic                valid_in,
    output logic [7:0]          char_q,
    output logic                valid_q
);

    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic       valid_reg;
    logic       valid_next;

    // Shift takes the neighbor's slot; clear alone empties this one
    always_comb
    begin
        char_next  = char_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            char_next  = char_in;
            valid_next = valid_in;
        end
        else if (ctrl.clear) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign char_q  = char_reg;
    assign valid_q = valid_reg;

endmodule

### hw/rtl/banner_service_classifier.sv
// Top level of the banner service classifier: byte cleaning, window chain, hit flags, result.
//
// Usage:
//   in channel  (in_valid / in_ready / in_data): one banner byte per transfer.
//     first_item opens a banner (clears hits and window, samples port_number),
//     byte_present qualifies data_byte, last_item requests the classification.
//   out channel (out_valid / out_ready / out_data): one result per transfer
//     that carried last_item: service_code and attention_code.
// Throughput: one input transfer per cycle while in_ready is high. The window is a chain of four
//   character cells that shift once per kept character, and the hit flags are
//   set from the cells plus the incoming character in the same cycle.
// Output: the result is registered; it is offered in the cycle after the
//   transfer that carried last_item.
// Stall: the output register holds the result while out_ready is low; in_ready
//   stays high whenever the register is empty or being drained this cycle.
// Reset: rst_n clears window, hits, kept count, held port and the output
//   valid; no clearing pass is needed.
module banner_service_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bsc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bsc_pkg::out_item_t out_data
);

    localparam int DEPTH = bsc_pkg::WIN_DEPTH;

    logic                        in_xfer;
    logic                        out_xfer;
    bsc_pkg::clean_t             cln;
    logic                        kept;
    logic                        start;
    logic [bsc_pkg::KEPT_W-1:0]  count_reg;
    logic [bsc_pkg::KEPT_W-1:0]  count_next;
    logic [bsc_pkg::KEPT_W-1:0]  count_eff;
    logic [3:0]                  hits_reg;
    logic [3:0]                  hits_next;
    logic [3:0]                  hits_eff;
    logic [15:0]                 port_reg;
    logic [15:0]                 port_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    bsc_pkg::out_item_t          out_data_reg;
    bsc_pkg::out_item_t          out_data_next;
    bsc_pkg::cell_ctrl_t         cell_ctrl;
    logic [7:0]                  win_char [DEPTH];
    logic                        win_valid_q [DEPTH];
    logic                        win_valid [DEPTH];
    logic [7:0]                  chain_char [DEPTH];
    logic                        chain_valid [DEPTH];

    // Handshakes
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;

    // Cleaning and limit check
    assign start     = in_xfer && in_data.first_item;
    assign cln       = bsc_pkg::clean_byte(in_data.data_byte);
    assign count_eff = start ? '0 : count_reg;
    assign kept      = in_xfer && in_data.byte_present && cln.keep
                       && (count_eff < bsc_pkg::KEPT_W'(bsc_pkg::KEPT_LIMIT));

    // Window chain control
    assign cell_ctrl.clear = start;
    assign cell_ctrl.shift = kept;

    // Window as seen by this transfer: emptied when a banner opens
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++) begin
            win_valid[k] = win_valid_q[k] && !start;
        end
    end

    // Neighbor feeds: newest character enters cell 0
    always_comb
    begin
        chain_char[0]  = cln.ch;
        chain_valid[0] = 1'b1;
        for (int k = 1; k < DEPTH; k++) begin
            chain_char[k]  = win_char[k-1];
            chain_valid[k] = win_valid[k-1];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bsc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .char_in  (chain_char[g]),
            .valid_in (chain_valid[g]),
            .char_q   (win_char[g]),
            .valid_q  (win_valid_q[g])
        );
    end

    // Pattern match on cells plus incoming character
    always_comb
    begin
        hits_eff  = start ? 4'd0 : hits_reg;
        hits_next = hits_eff;
        if (kept) begin
            if (win_valid[2] && win_char[2] == bsc_pkg::CH_S && win_char[1] == bsc_pkg::CH_S
                && win_char[0] == bsc_pkg::CH_H && cln.ch == bsc_pkg::CH_DASH) begin
                hits_next[bsc_pkg::HIT_SSH] = 1'b1;
            end
            if (win_valid[3] && win_char[3] == bsc_pkg::CH_H && win_char[2] == bsc_pkg::CH_T
                && win_char[1] == bsc_pkg::CH_T && win_char[0] == bsc_pkg::CH_P
                && cln.ch == bsc_pkg::CH_SLASH) begin
                hits_next[bsc_pkg::HIT_HTTP] = 1'b1;
            end
            if (win_valid[2] && win_char[2] == bsc_pkg::CH_S && win_char[1] == bsc_pkg::CH_M
                && win_char[0] == bsc_pkg::CH_T && cln.ch == bsc_pkg::CH_P) begin
                hits_next[bsc_pkg::HIT_SMTP] = 1'b1;
            end
            if (win_valid[1] && win_char[1] == bsc_pkg::CH_F && win_char[0] == bsc_pkg::CH_T
                && cln.ch == bsc_pkg::CH_P) begin
                hits_next[bsc_pkg::HIT_FTP] = 1'b1;
            end
        end
    end

    // Count and port
    assign count_next = kept ? count_eff + bsc_pkg::KEPT_W'(1) : count_eff;
    assign port_next  = start ? in_data.port_number : port_reg;

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (in_xfer && in_data.last_item) begin
            out_valid_next = 1'b1;
            out_data_next  = bsc_pkg::classify(hits_next, port_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            hits_reg      <= 4'd0;
            port_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_xfer) begin
                count_reg <= count_next;
                hits_reg  <= hits_next;
                port_reg  <= port_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A transfer that closes a banner always yields a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.last_item |=> out_valid)
        else $error("last transfer did not produce a result");

    // A drained result with no new last transfer leaves the output empty
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !(in_xfer && in_data.last_item) |=> !out_valid)
        else $error("result repeated after transfer");

    // Kept count never passes the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bsc_pkg::KEPT_W'(bsc_pkg::KEPT_LIMIT))
        else $error("kept count beyond limit");

    // Attention code follows the service code for FTP results
    a_attention: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.service_code == bsc_pkg::SVC_FTP
        |-> out_data.attention_code == bsc_pkg::ATT_FILE)
        else $error("ftp result without file transfer attention");
`endif

endmodule
